/* hw/rtl/md4_pkg.sv */
// MD4 engine package: control word and status types, microcode program, constants.
// Used by every module of the MD4 engine; no dependencies.
`default_nettype none

package md4_pkg;

	localparam int UPC_W = 7;

	localparam logic [31:0] IV_WORDS [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};
	localparam logic [31:0] ROUND_K1 = 32'h5a827999;
	localparam logic [31:0] ROUND_K2 = 32'h6ed9eba1;
	localparam logic [31:0] PAD_WORD = 32'h00000080;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_FILL_80,
		OP_FILL_ZERO,
		OP_FILL_LEN_LO,
		OP_FILL_LEN_HI,
		OP_INIT,
		OP_STEP,
		OP_FEED,
		OP_EMIT,
		OP_FINISH
	} uop_t;

	typedef enum logic [2:0] {
		CND_NEXT,
		CND_JUMP,
		CND_CALL,
		CND_RET,
		CND_CALL_WRAP,
		CND_JUMP_NOT_LAST,
		CND_JUMP_NO80,
		CND_JUMP_AT14
	} cond_t;

	typedef struct packed {
		uop_t             op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
		logic [3:0]       msg_idx;
		logic [1:0]       rnd;
		logic [1:0]       tgt;
		logic [4:0]       rot;
		logic [1:0]       sel;
	} ctrl_t;

	typedef struct packed {
		logic hold;
		logic wrap;
		logic at14;
		logic last;
		logic need80;
	} stat_t;

	// program addresses
	localparam logic [UPC_W-1:0] A_ACCEPT = 7'd0;
	localparam logic [UPC_W-1:0] A_WRAP0  = 7'd1;
	localparam logic [UPC_W-1:0] A_LAST   = 7'd2;
	localparam logic [UPC_W-1:0] A_PAD    = 7'd3;
	localparam logic [UPC_W-1:0] A_FILL80 = 7'd4;
	localparam logic [UPC_W-1:0] A_WRAP1  = 7'd5;
	localparam logic [UPC_W-1:0] A_ZLOOP  = 7'd6;
	localparam logic [UPC_W-1:0] A_ZFILL  = 7'd7;
	localparam logic [UPC_W-1:0] A_WRAP2  = 7'd8;
	localparam logic [UPC_W-1:0] A_ZBACK  = 7'd9;
	localparam logic [UPC_W-1:0] A_LEN_LO = 7'd10;
	localparam logic [UPC_W-1:0] A_LEN_HI = 7'd11;
	localparam logic [UPC_W-1:0] A_FINAL  = 7'd12;
	localparam logic [UPC_W-1:0] A_EMIT0  = 7'd13;
	localparam logic [UPC_W-1:0] A_EMIT1  = 7'd14;
	localparam logic [UPC_W-1:0] A_EMIT2  = 7'd15;
	localparam logic [UPC_W-1:0] A_EMIT3  = 7'd16;
	localparam logic [UPC_W-1:0] A_FINISH = 7'd17;
	localparam logic [UPC_W-1:0] A_INIT   = 7'd32;
	localparam logic [UPC_W-1:0] A_STEP0  = 7'd33;
	localparam logic [UPC_W-1:0] A_FEED   = 7'd81;

	function automatic logic [31:0] md4_rotl(input logic [31:0] v, input logic [4:0] s);
		return (v << s) | (v >> (6'd32 - 6'(s)));
	endfunction

	function automatic logic [31:0] md4_round_f(input logic [1:0] rnd,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		logic [31:0] f;
		unique case (rnd)
			2'd0:    f = (x & y) | (~x & z);
			2'd1:    f = (x & y) | (x & z) | (y & z);
			default: f = x ^ y ^ z;
		endcase
		return f;
	endfunction

	function automatic logic [31:0] md4_round_k(input logic [1:0] rnd);
		logic [31:0] k;
		unique case (rnd)
			2'd0:    k = 32'h0;
			2'd1:    k = ROUND_K1;
			default: k = ROUND_K2;
		endcase
		return k;
	endfunction

	// microcode ROM
	function automatic ctrl_t md4_ucode(input logic [UPC_W-1:0] addr);
		ctrl_t      cw;
		logic [5:0] s;
		logic [3:0] i;
		cw = '0;
		cw.op = OP_NOP;
		cw.cond = CND_NEXT;
		s = 6'(addr - A_STEP0);
		i = s[3:0];
		if (addr >= A_STEP0 && addr < A_FEED) begin
			cw.op = OP_STEP;
			cw.rnd = s[5:4];
			cw.tgt = 2'd0 - s[1:0];
			unique case (s[5:4])
				2'd0:    cw.msg_idx = i;
				2'd1:    cw.msg_idx = {i[1:0], i[3:2]};
				default: cw.msg_idx = {i[0], i[1], i[2], i[3]};
			endcase
			unique case ({s[5:4], s[1:0]})
				4'b00_00, 4'b01_00, 4'b10_00: cw.rot = 5'd3;
				4'b00_01: cw.rot = 5'd7;
				4'b00_10: cw.rot = 5'd11;
				4'b00_11: cw.rot = 5'd19;
				4'b01_01: cw.rot = 5'd5;
				4'b01_10: cw.rot = 5'd9;
				4'b01_11: cw.rot = 5'd13;
				4'b10_01: cw.rot = 5'd9;
				4'b10_10: cw.rot = 5'd11;
				4'b10_11: cw.rot = 5'd15;
				default:  cw.rot = 5'd3;
			endcase
		end else begin
			unique case (addr)
				A_ACCEPT: cw.op = OP_ACCEPT;
				A_WRAP0: begin
					cw.cond = CND_CALL_WRAP;
					cw.target = A_INIT;
				end
				A_LAST: begin
					cw.cond = CND_JUMP_NOT_LAST;
					cw.target = A_ACCEPT;
				end
				A_PAD: begin
					cw.cond = CND_JUMP_NO80;
					cw.target = A_ZLOOP;
				end
				A_FILL80: cw.op = OP_FILL_80;
				A_WRAP1: begin
					cw.cond = CND_CALL_WRAP;
					cw.target = A_INIT;
				end
				A_ZLOOP: begin
					cw.cond = CND_JUMP_AT14;
					cw.target = A_LEN_LO;
				end
				A_ZFILL: cw.op = OP_FILL_ZERO;
				A_WRAP2: begin
					cw.cond = CND_CALL_WRAP;
					cw.target = A_INIT;
				end
				A_ZBACK: begin
					cw.cond = CND_JUMP;
					cw.target = A_ZLOOP;
				end
				A_LEN_LO: cw.op = OP_FILL_LEN_LO;
				A_LEN_HI: cw.op = OP_FILL_LEN_HI;
				A_FINAL: begin
					cw.cond = CND_CALL;
					cw.target = A_INIT;
				end
				A_EMIT0: begin
					cw.op = OP_EMIT;
					cw.sel = 2'd0;
				end
				A_EMIT1: begin
					cw.op = OP_EMIT;
					cw.sel = 2'd1;
				end
				A_EMIT2: begin
					cw.op = OP_EMIT;
					cw.sel = 2'd2;
				end
				A_EMIT3: begin
					cw.op = OP_EMIT;
					cw.sel = 2'd3;
				end
				A_FINISH: begin
					cw.op = OP_FINISH;
					cw.cond = CND_JUMP;
					cw.target = A_ACCEPT;
				end
				A_INIT: cw.op = OP_INIT;
				A_FEED: begin
					cw.op = OP_FEED;
					cw.cond = CND_RET;
				end
				default: begin
					cw.cond = CND_JUMP;
					cw.target = A_ACCEPT;
				end
			endcase
		end
		return cw;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/md4_in_if.sv */
// MD4 engine input channel: message words with byte count and last flag.
// No dependencies.
`default_nettype none

interface md4_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last_word;

	modport source (output valid, data_word, byte_count, last_word, input ready);
	modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/md4_out_if.sv */
// MD4 engine output channel: digest words, A first, with a final-word flag.
// No dependencies.
`default_nettype none

interface md4_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        digest_last;

	modport source (output valid, digest_word, digest_last, input ready);
	modport sink (input valid, digest_word, digest_last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/md4_sequencer.sv */
// MD4 microsequencer: step counter, return register, jump conditions, ROM lookup.
// Depends on md4_pkg.
`default_nettype none

module md4_sequencer
	import md4_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	logic [UPC_W-1:0] upc_q, upc_d;
	logic [UPC_W-1:0] ret_q, ret_d;
	logic [UPC_W-1:0] upc_inc;

	assign ctrl = md4_ucode(upc_q);
	assign upc_inc = upc_q + 7'd1;

	always_comb begin
		upc_d = upc_inc;
		ret_d = ret_q;
		if (stat.hold) begin
			upc_d = upc_q;
		end else begin
			unique case (ctrl.cond)
				CND_NEXT: upc_d = upc_inc;
				CND_JUMP: upc_d = ctrl.target;
				CND_CALL: begin
					upc_d = ctrl.target;
					ret_d = upc_inc;
				end
				CND_RET: upc_d = ret_q;
				CND_CALL_WRAP: begin
					if (stat.wrap) begin
						upc_d = ctrl.target;
						ret_d = upc_inc;
					end
				end
				CND_JUMP_NOT_LAST: if (!stat.last) upc_d = ctrl.target;
				CND_JUMP_NO80: if (!stat.need80) upc_d = ctrl.target;
				CND_JUMP_AT14: if (stat.at14) upc_d = ctrl.target;
				default: upc_d = A_ACCEPT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= A_ACCEPT;
			ret_q <= A_ACCEPT;
		end else begin
			upc_q <= upc_d;
			ret_q <= ret_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/md4_datapath.sv */
// MD4 datapath: block buffer, working and chaining words, byte counter, digest register.
// Depends on md4_pkg, md4_in_if and md4_out_if.
`default_nettype none

module md4_datapath
	import md4_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  ctrl_t        ctrl,
	output stat_t        stat,
	md4_in_if.sink       in_ch,
	md4_out_if.source    out_ch
);

	logic [31:0] buf_q [16];
	logic [31:0] work_q [4];
	logic [31:0] chain_q [4];
	logic [3:0]  widx_q;
	logic [60:0] total_q;
	logic        last_q;
	logic        need80_q;
	logic        out_valid_q;
	logic [31:0] digest_word_q;
	logic        digest_last_q;

	logic        accept;
	logic [2:0]  n_bytes;
	logic [2:0]  add_bytes;
	logic [31:0] keep;
	logic [31:0] pad;
	logic [31:0] acc_word;
	logic        fill_en;
	logic [31:0] fill_val;
	logic        emit_go;
	logic [1:0]  ix, iy, iz;
	logic [31:0] step_sum;

	assign in_ch.ready = (ctrl.op == OP_ACCEPT);
	assign accept = in_ch.valid && in_ch.ready;

	assign n_bytes = (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
	assign add_bytes = in_ch.last_word ? n_bytes : 3'd4;

	always_comb begin
		unique case (n_bytes[1:0])
			2'd0: begin
				keep = 32'h0;
				pad = 32'h00000080;
			end
			2'd1: begin
				keep = 32'h000000ff;
				pad = 32'h00008000;
			end
			2'd2: begin
				keep = 32'h0000ffff;
				pad = 32'h00800000;
			end
			default: begin
				keep = 32'h00ffffff;
				pad = 32'h80000000;
			end
		endcase
	end

	assign acc_word = (!in_ch.last_word || n_bytes[2]) ? in_ch.data_word
		: ((in_ch.data_word & keep) | pad);

	always_comb begin
		fill_en = 1'b0;
		fill_val = 32'h0;
		unique case (ctrl.op)
			OP_ACCEPT: begin
				fill_en = accept;
				fill_val = acc_word;
			end
			OP_FILL_80: begin
				fill_en = 1'b1;
				fill_val = PAD_WORD;
			end
			OP_FILL_ZERO: fill_en = 1'b1;
			OP_FILL_LEN_LO: begin
				fill_en = 1'b1;
				fill_val = {total_q[28:0], 3'b000};
			end
			OP_FILL_LEN_HI: begin
				fill_en = 1'b1;
				fill_val = total_q[60:29];
			end
			default: fill_en = 1'b0;
		endcase
	end

	assign emit_go = (ctrl.op == OP_EMIT) && (!out_valid_q || out_ch.ready);

	assign stat.hold = ((ctrl.op == OP_ACCEPT) && !accept) || ((ctrl.op == OP_EMIT) && !emit_go);
	assign stat.wrap = (widx_q == 4'd0);
	assign stat.at14 = (widx_q == 4'd14);
	assign stat.last = last_q;
	assign stat.need80 = need80_q;

	// compression step
	assign ix = ctrl.tgt + 2'd1;
	assign iy = ctrl.tgt + 2'd2;
	assign iz = ctrl.tgt + 2'd3;
	assign step_sum = work_q[ctrl.tgt]
		+ md4_round_f(ctrl.rnd, work_q[ix], work_q[iy], work_q[iz])
		+ buf_q[ctrl.msg_idx] + md4_round_k(ctrl.rnd);

	always_ff @(posedge clk) begin
		if (fill_en)
			buf_q[widx_q] <= fill_val;
		if (ctrl.op == OP_INIT) begin
			for (int k = 0; k < 4; k++)
				work_q[k] <= chain_q[k];
		end else if (ctrl.op == OP_STEP) begin
			work_q[ctrl.tgt] <= md4_rotl(step_sum, ctrl.rot);
		end
		if (emit_go) begin
			digest_word_q <= chain_q[ctrl.sel];
			digest_last_q <= (ctrl.sel == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++)
				chain_q[k] <= IV_WORDS[k];
			widx_q <= '0;
			total_q <= '0;
			last_q <= 1'b0;
			need80_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fill_en)
				widx_q <= widx_q + 4'd1;
			if (accept) begin
				total_q <= total_q + 61'(add_bytes);
				last_q <= in_ch.last_word;
				need80_q <= in_ch.last_word && n_bytes[2];
			end else if (ctrl.op == OP_FINISH) begin
				total_q <= '0;
				last_q <= 1'b0;
				need80_q <= 1'b0;
			end
			if (ctrl.op == OP_FEED) begin
				for (int k = 0; k < 4; k++)
					chain_q[k] <= chain_q[k] + work_q[k];
			end else if (ctrl.op == OP_FINISH) begin
				for (int k = 0; k < 4; k++)
					chain_q[k] <= IV_WORDS[k];
			end
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.digest_word = digest_word_q;
	assign out_ch.digest_last = digest_last_q;

endmodule

`default_nettype wire

/* hw/rtl/md4_hash_engine.sv */
// MD4 hash engine: a request inside a block passes the accept, wrap and last steps;
// the 16th word of a block also runs the compression (init, 48 round steps at one
// per cycle, feed-forward). A last word pads, runs one or two compressions and
// puts out four digest words one per cycle when the sink is ready, then finishes.
// Reset (arst_n low): chaining words to the MD4 initial vector, byte and word counts
// to zero, sequencer at the request-accept step; block buffer is not cleared.
// Depends on md4_pkg, md4_in_if, md4_out_if, md4_sequencer and md4_datapath.
`default_nettype none

module md4_hash_engine
	import md4_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	md4_in_if.sink    in_ch,
	md4_out_if.source out_ch
);

	ctrl_t ctrl;
	stat_t stat;

	md4_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	md4_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire
